### rtl/cbf_pkg.sv
// Shared types, constants and codes of the counting Bloom filter.
`timescale 1ns / 1ps
package cbf_pkg;

	// Default sizing, handed to the top-level parameters
	localparam int MAX_BUCKETS_DEF   = 65536;
	localparam int COUNTER_WIDTH_DEF = 8;
	localparam int MAX_HASHES_DEF    = 8;

	// Field and register widths
	localparam int OP_W      = 2;
	localparam int KEY_W     = 64;
	localparam int KB_W      = 4;
	localparam int MIN_W     = 16;
	localparam int HC_W      = 4;
	localparam int BC_W      = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;
	localparam int SEED_PAIRS = 4;
	localparam int KEY_BYTES_MAX = 8;

	// Hash constants
	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

	// Register reset values
	localparam logic [HC_W-1:0] HASH_COUNT_RST   = 4'd7;
	localparam logic [BC_W-1:0] BUCKET_COUNT_RST = 17'd65536;
	localparam logic [SEED_PAIRS-1:0][63:0] SEED_PAIR_RST = {
		64'd30064771078, 64'd21474836484, 64'd12884901890, 64'd4294967296
	};

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_EXISTS = 2'd1,
		OP_BOTH   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HASH_COUNT   = 3'd0,
		CFG_BUCKET_COUNT = 3'd1,
		CFG_SEED_PAIR_0  = 3'd2,
		CFG_SEED_PAIR_1  = 3'd3,
		CFG_SEED_PAIR_2  = 3'd4,
		CFG_SEED_PAIR_3  = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		F_IDLE, F_K1A, F_K1AW, F_K1BW, F_SEED, F_MA0, F_MA1, F_MA2,
		F_MB1, F_MB2, F_MOD, F_PUSH, F_REPLAY, F_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR, B_IDLE, B_RMW
	} back_state_t;

	// Control part of one queued counter command
	typedef struct packed {
		logic             do_ins;
		logic             do_chk;
		logic             has_idx;
		logic             last;
		logic [MIN_W-1:0] min_count;
	} cmd_ctl_t;

	localparam int CTL_W = $bits(cmd_ctl_t);

endpackage

### rtl/cbf_req_if.sv
// Request channel: one key word with its op.
`timescale 1ns / 1ps
interface cbf_req_if import cbf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key_value;
	logic [KB_W-1:0]  key_bytes;
	logic [MIN_W-1:0] min_count;
	modport source (output valid, op, key_value, key_bytes, min_count, input ready);
	modport sink   (input valid, op, key_value, key_bytes, min_count, output ready);
endinterface

### rtl/cbf_rsp_if.sv
// Response channel: one answer word per request.
`timescale 1ns / 1ps
interface cbf_rsp_if;
	logic valid;
	logic ready;
	logic present;
	modport source (output valid, present, input ready);
	modport sink   (input valid, present, output ready);
endinterface

### rtl/cbf_cfg_if.sv
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface cbf_cfg_if import cbf_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/counting_bloom_filter_top.sv
// Without stalls, an empty key skips the key multiplies, insert-then-exists adds a replay
// of the stored indices as checks, and a no-op or zero hashes skip hashing altogether.
// Each hash costs four multiplies on the shared 32x32 unit and a modulo by the bucket count.
// Throughput: one request at a time in the hash front; the counter back reads and updates
// each command and overlaps the next request's hashing through a 4-word queue.
// Reset: asynchronous, active low; after release all MAX_BUCKETS counter RAM entries are
// swept to zero, during which no request is taken (configuration writes are).
`timescale 1ns / 1ps
module counting_bloom_filter_top import cbf_pkg::*; #(
	parameter int MAX_BUCKETS   = MAX_BUCKETS_DEF,
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
	parameter int MAX_HASHES    = MAX_HASHES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cbf_req_if.sink   req,
	cbf_rsp_if.source rsp,
	cbf_cfg_if.sink   cfg
);
	localparam int IW     = $clog2(MAX_BUCKETS);
	localparam int QDEPTH = 4;

	logic [HC_W-1:0]             hash_count_q;
	logic [BC_W-1:0]             bucket_count_q;
	logic [SEED_PAIRS-1:0][63:0] seed_pair_q;
	logic                        push, pop, full, empty, clr_done;
	cmd_ctl_t                    push_ctl, head_ctl;
	logic [IW-1:0]               push_idx, head_idx;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q   <= HASH_COUNT_RST;
			bucket_count_q <= BUCKET_COUNT_RST;
			seed_pair_q    <= SEED_PAIR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_HASH_COUNT:   hash_count_q   <= cfg.data[HC_W-1:0];
				CFG_BUCKET_COUNT: bucket_count_q <= cfg.data[BC_W-1:0];
				CFG_SEED_PAIR_0:  seed_pair_q[0] <= cfg.data;
				CFG_SEED_PAIR_1:  seed_pair_q[1] <= cfg.data;
				CFG_SEED_PAIR_2:  seed_pair_q[2] <= cfg.data;
				CFG_SEED_PAIR_3:  seed_pair_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	cbf_front #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.MAX_HASHES  (MAX_HASHES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.clr_done     (clr_done),
		.hash_count   (hash_count_q),
		.bucket_count (bucket_count_q),
		.seed_pair    (seed_pair_q),
		.push         (push),
		.push_ctl     (push_ctl),
		.push_idx     (push_idx),
		.full         (full)
	);

	cbf_fifo #(
		.WIDTH (CTL_W + IW),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_ctl, push_idx}),
		.full   (full),
		.pop    (pop),
		.dout   ({head_ctl, head_idx}),
		.empty  (empty)
	);

	cbf_back #(
		.MAX_BUCKETS   (MAX_BUCKETS),
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head_ctl (head_ctl),
		.head_idx (head_idx),
		.pop      (pop),
		.clr_done (clr_done),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// Queue is never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue overflow");

	// Nothing is queued while the counter RAM is being cleared
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> empty) else $error("command queued during clear");

	// Back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command queue underflow");
`endif
endmodule

### rtl/cbf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/cbf_fifo.sv
// Small command queue between the hash front and the counter back.
`timescale 1ns / 1ps
module cbf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Store the word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end
endmodule

### rtl/cbf_mul64.sv
// 64x64 multiplier, low 64 bits, on one 32x32 unit as a sequence of partial products.
`timescale 1ns / 1ps
module cbf_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic [63:0] a_q, b_q, pp_q;
	logic [31:0] cr_q;
	logic [1:0]  step_q;
	logic        busy_q, done_q;
	logic [31:0] mx, my;
	logic [63:0] mp;

	// Pick the partial product for this step
	always_comb begin
		case (step_q)
			2'd0: begin
				mx = a_q[31:0];
				my = b_q[31:0];
			end
			2'd1: begin
				mx = a_q[31:0];
				my = b_q[63:32];
			end
			default: begin
				mx = a_q[63:32];
				my = b_q[31:0];
			end
		endcase
	end

	assign mp   = {32'b0, mx} * {32'b0, my};
	assign prod = pp_q + {cr_q, 32'b0};
	assign done = done_q;

	// Sequence the three steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	// Accumulate partial products
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			case (step_q)
				2'd0:    pp_q <= mp;
				2'd1:    cr_q <= mp[31:0];
				default: cr_q <= cr_q + mp[31:0];
			endcase
		end
	end
endmodule

### rtl/cbf_front.sv
// Front: accepts requests, hashes the key per seed, queues counter commands.
`timescale 1ns / 1ps
module cbf_front import cbf_pkg::*; #(
	parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
	parameter int MAX_HASHES  = MAX_HASHES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cbf_req_if.sink                       req,
	input  logic                          clr_done,
	input  logic [HC_W-1:0]               hash_count,
	input  logic [BC_W-1:0]               bucket_count,
	input  logic [SEED_PAIRS-1:0][63:0]   seed_pair,
	output logic                          push,
	output cmd_ctl_t                      push_ctl,
	output logic [$clog2(MAX_BUCKETS)-1:0] push_idx,
	input  logic                          full
);
	localparam int IW  = $clog2(MAX_BUCKETS);
	localparam int IBW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int RW  = BC_W + 1;

	front_state_t     state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q, k1_q, a_q, b_q, div_q, masked, seed64, h1, h2, h1n, h2n;
	logic [KB_W-1:0]  len_q, kb_clamp;
	logic [MIN_W-1:0] min_q;
	logic [RW-1:0]    rem_q, rem_d;
	logic [3:0]       dcnt_q;
	logic [HC_W-1:0]  i_q, n_act;
	logic [BC_W-1:0]  d_act;
	logic [IW-1:0]    idxbuf_q [MAX_HASHES];
	logic [31:0]      seed;
	logic             last_hash, accept;
	logic             mul_start, mul_done;
	logic [63:0]      mul_a, mul_b, mul_prod, mixed;

	cbf_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Clamp configuration and key length to the supported range
	always_comb begin
		n_act = (hash_count > HC_W'(MAX_HASHES)) ? HC_W'(MAX_HASHES) : hash_count;
		if (bucket_count == '0) begin
			d_act = BC_W'(1);
		end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
			d_act = BC_W'(MAX_BUCKETS);
		end else begin
			d_act = bucket_count;
		end
		kb_clamp = (req.key_bytes > KB_W'(KEY_BYTES_MAX)) ? KB_W'(KEY_BYTES_MAX) : req.key_bytes;
	end

	// Mask key bytes beyond the length
	always_comb begin
		for (int b = 0; b < KEY_BYTES_MAX; b++) begin
			masked[8*b +: 8] = (KB_W'(b) < len_q) ? key_q[8*b +: 8] : 8'h00;
		end
	end

	assign seed      = i_q[0] ? seed_pair[i_q[2:1]][63:32] : seed_pair[i_q[2:1]][31:0];
	assign seed64    = {32'b0, seed};
	assign h1        = seed64 ^ k1_q ^ {60'b0, len_q};
	assign h2        = seed64 ^ {60'b0, len_q};
	assign h1n       = h1 + h2;
	assign h2n       = h2 + h1n;
	assign mixed     = mul_prod ^ (mul_prod >> 33);
	assign last_hash = ((i_q + HC_W'(1)) == n_act);
	assign accept    = req.valid && req.ready;

	// Four remainder bits per cycle
	always_comb begin
		logic [RW-1:0]    r;
		logic [KEY_W-1:0] dv;
		r  = rem_q;
		dv = div_q;
		for (int j = 0; j < 4; j++) begin
			r  = {r[RW-2:0], dv[KEY_W-1]};
			dv = dv << 1;
			if (r >= {1'b0, d_act}) begin
				r = r - {1'b0, d_act};
			end
		end
		rem_d = r;
	end

	// Next state, multiplier strobes and queue push
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		push      = 1'b0;
		push_idx  = IW'(rem_q);
		push_ctl  = '{do_ins: (op_q == OP_INSERT) || (op_q == OP_BOTH),
			do_chk: (op_q == OP_EXISTS), has_idx: 1'b1,
			last: last_hash && (op_q != OP_BOTH), min_count: min_q};
		case (state_q)
			F_IDLE: begin
				req.ready = clr_done;
				if (accept) begin
					if (op_t'(req.op) == OP_NOP || n_act == '0) begin
						state_d = F_EMIT;
					end else if (kb_clamp == '0) begin
						state_d = F_SEED;
					end else begin
						state_d = F_K1A;
					end
				end
			end
			F_K1A: begin
				mul_start = 1'b1;
				mul_a     = masked;
				mul_b     = MM_C1;
				state_d   = F_K1AW;
			end
			F_K1AW: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = {mul_prod[32:0], mul_prod[63:33]};
					mul_b     = MM_C2;
					state_d   = F_K1BW;
				end
			end
			F_K1BW: begin
				if (mul_done) begin
					state_d = F_SEED;
				end
			end
			F_SEED: state_d = F_MA0;
			F_MA0: begin
				mul_start = 1'b1;
				mul_a     = a_q ^ (a_q >> 33);
				mul_b     = MM_F1;
				state_d   = F_MA1;
			end
			F_MA1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mixed;
					mul_b     = MM_F2;
					state_d   = F_MA2;
				end
			end
			F_MA2: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = b_q ^ (b_q >> 33);
					mul_b     = MM_F1;
					state_d   = F_MB1;
				end
			end
			F_MB1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mixed;
					mul_b     = MM_F2;
					state_d   = F_MB2;
				end
			end
			F_MB2: begin
				if (mul_done) begin
					state_d = F_MOD;
				end
			end
			F_MOD: begin
				if (dcnt_q == 4'd15) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					push = 1'b1;
					if (!last_hash) begin
						state_d = F_SEED;
					end else if (op_q == OP_BOTH) begin
						state_d = F_REPLAY;
					end else begin
						state_d = F_IDLE;
					end
				end
			end
			F_REPLAY: begin
				push_idx = idxbuf_q[i_q[IBW-1:0]];
				push_ctl = '{do_ins: 1'b0, do_chk: 1'b1, has_idx: 1'b1,
					last: last_hash, min_count: min_q};
				if (!full) begin
					push = 1'b1;
					if (last_hash) begin
						state_d = F_IDLE;
					end
				end
			end
			F_EMIT: begin
				push_ctl = '{do_ins: 1'b0,
					do_chk: (op_q == OP_EXISTS) || (op_q == OP_BOTH),
					has_idx: 1'b0, last: 1'b1, min_count: min_q};
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the item, step the hash and the remainder
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(req.op);
			key_q <= req.key_value;
			len_q <= kb_clamp;
			min_q <= req.min_count;
			k1_q  <= '0;
			i_q   <= '0;
		end
		if (state_q == F_K1BW && mul_done) begin
			k1_q <= mul_prod;
		end
		if (state_q == F_SEED) begin
			a_q <= h1n;
			b_q <= h2n;
		end
		if (state_q == F_MA2 && mul_done) begin
			a_q <= mixed;
		end
		if (state_q == F_MB2 && mul_done) begin
			div_q  <= a_q + {mixed[62:0], 1'b0};
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (state_q == F_MOD) begin
			rem_q  <= rem_d;
			div_q  <= div_q << 4;
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (state_q == F_PUSH && !full) begin
			idxbuf_q[i_q[IBW-1:0]] <= IW'(rem_q);
			i_q <= last_hash ? '0 : i_q + HC_W'(1);
		end
		if (state_q == F_REPLAY && !full) begin
			i_q <= i_q + HC_W'(1);
		end
	end
endmodule

### rtl/cbf_back.sv
// Back: clears the counter RAM, runs counter updates and checks, drives answers.
`timescale 1ns / 1ps
module cbf_back import cbf_pkg::*; #(
	parameter int MAX_BUCKETS   = MAX_BUCKETS_DEF,
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  cmd_ctl_t                       head_ctl,
	input  logic [$clog2(MAX_BUCKETS)-1:0] head_idx,
	output logic                           pop,
	output logic                           clr_done,
	cbf_rsp_if.source                      rsp
);
	localparam int IW = $clog2(MAX_BUCKETS);
	localparam int CW = COUNTER_WIDTH;

	back_state_t      state_q, state_d;
	logic [IW-1:0]    clr_q, idx_q, waddr;
	cmd_ctl_t         ctl_q;
	logic             fail_q, fail_n, rsp_valid_q, present_q;
	logic             we, fin, fin_present;
	logic [CW-1:0]    wdata, rdata;

	cbf_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head_idx),
		.rdata (rdata)
	);

	assign clr_done    = (state_q != B_CLEAR);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.present = present_q;

	// Sweep, pop, update and finish
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		we          = 1'b0;
		waddr       = idx_q;
		wdata       = rdata + CW'(1);
		fail_n      = fail_q;
		fin         = 1'b0;
		fin_present = 1'b0;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == IW'(MAX_BUCKETS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!empty && (!head_ctl.last || !rsp_valid_q)) begin
					pop = 1'b1;
					if (head_ctl.has_idx) begin
						state_d = B_RMW;
					end else begin
						fin         = 1'b1;
						fin_present = head_ctl.do_chk &&
							(head_ctl.min_count == '0 || !fail_q);
					end
				end
			end
			B_RMW: begin
				we     = ctl_q.do_ins && (rdata != '1);
				fail_n = fail_q || (ctl_q.do_chk && (MIN_W'(rdata) < ctl_q.min_count));
				fin    = ctl_q.last;
				fin_present = ctl_q.do_chk && (ctl_q.min_count == '0 || !fail_n);
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Hold state, sweep address, check flag and answer word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			fail_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (fin) begin
				fail_q      <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else begin
				fail_q <= fail_n;
				if (rsp.ready) begin
					rsp_valid_q <= 1'b0;
				end
			end
		end
	end

	// Latch the popped command and the answer bit
	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_q <= head_ctl;
			idx_q <= head_idx;
		end
		if (fin) begin
			present_q <= fin_present;
		end
	end
endmodule
